@@ sv/mwm_pkg.sv @@
// Shared constants for the mecanum wheel mixer.
`timescale 1ns / 1ps

package mwm_pkg;

    localparam int VEL_BITS_DEFAULT = 15;
    localparam int MAX_BITS         = 15;
    localparam int WHEEL_BITS       = 16;
    localparam int NUM_WHEELS       = 4;
    // Quotient never exceeds the speed limit, so it needs as many bits
    localparam int QUO_BITS         = MAX_BITS;

    localparam logic [MAX_BITS-1:0] MAX_SPEED_RESET = 15'd8192;

endpackage

@@ sv/mecanum_wheel_mixer_core.sv @@
// Top level of the mecanum wheel mixer: front end, divider cell row, output register.
`timescale 1ns / 1ps

// Usage
//   s_* channel takes one chassis command per request: s_tdata holds
//   vel_forward, vel_sideways, vel_rotate (VEL_BITS each, signed).
//   m_* channel gives one result per command: m_tdata holds wheel_a..wheel_d
//   (16 bits each, signed), m_tuser holds was_scaled.
//   cfg_wr_en / cfg_wr_data set max_wheel_speed; write only while idle.
// Pipeline
//   An accepted request passes to m_tvalid through three front
//   stages (mix, largest search, scale product), one cell per quotient bit
//   (15 cells), and the output register.
//   Throughput is one request per cycle while the output is not stalled; every stage holds one request.
// Reset
//   All stages empty, max_wheel_speed = 8192.
// Stall
//   A stalled output holds its request; stages behind it keep filling, and
//   s_tready drops only once every stage is occupied.
module mecanum_wheel_mixer_core
    import mwm_pkg::*;
#(
    parameter int VEL_BITS = VEL_BITS_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // vel_forward, vel_sideways, vel_rotate; zero padded to whole bytes
    input  logic [((3*VEL_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // wheel_a, wheel_b, wheel_c, wheel_d
    output logic [NUM_WHEELS*WHEEL_BITS-1:0]   m_tdata,
    // was_scaled
    output logic [0:0]                         m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [MAX_BITS-1:0]                cfg_wr_data
);

    localparam int MAG_W = VEL_BITS + 1;

    logic [MAX_BITS-1:0] max_speed_reg, max_speed_next;

    logic [QUO_BITS:0]                                   c_valid;
    logic [QUO_BITS:0]                                   c_ready;
    logic [QUO_BITS:0][NUM_WHEELS-1:0][MAG_W-1:0]        c_rem;
    logic [QUO_BITS:0][NUM_WHEELS-1:0][QUO_BITS-1:0]     c_low;
    logic [QUO_BITS:0][NUM_WHEELS-1:0][QUO_BITS-1:0]     c_quo;
    logic [QUO_BITS:0][MAG_W-1:0]                        c_div;
    logic [QUO_BITS:0][NUM_WHEELS-1:0]                   c_neg;
    logic [QUO_BITS:0]                                   c_scaled;

    logic                                   out_valid_reg, out_valid_next;
    logic [NUM_WHEELS*WHEEL_BITS-1:0]       out_data_reg, out_data_next;
    logic                                   out_scaled_reg;
    logic [WHEEL_BITS-1:0]                  mag16 [NUM_WHEELS];

    assign max_speed_next = cfg_wr_en ? cfg_wr_data : max_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_speed_reg <= MAX_SPEED_RESET;
        else
            max_speed_reg <= max_speed_next;
    end

    mwm_front #(
        .VEL_BITS (VEL_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .vel_forward  (s_tdata[VEL_BITS-1:0]),
        .vel_sideways (s_tdata[2*VEL_BITS-1:VEL_BITS]),
        .vel_rotate   (s_tdata[3*VEL_BITS-1:2*VEL_BITS]),
        .max_speed    (max_speed_reg),
        .out_valid    (c_valid[0]),
        .out_ready    (c_ready[0]),
        .out_rem      (c_rem[0]),
        .out_low      (c_low[0]),
        .out_div      (c_div[0]),
        .out_neg      (c_neg[0]),
        .out_scaled   (c_scaled[0])
    );

    assign c_quo[0] = '0;

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_cell
        mwm_div_cell #(
            .VEL_BITS (VEL_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (c_valid[i]),
            .in_ready   (c_ready[i]),
            .in_rem     (c_rem[i]),
            .in_low     (c_low[i]),
            .in_quo     (c_quo[i]),
            .in_div     (c_div[i]),
            .in_neg     (c_neg[i]),
            .in_scaled  (c_scaled[i]),
            .out_valid  (c_valid[i+1]),
            .out_ready  (c_ready[i+1]),
            .out_rem    (c_rem[i+1]),
            .out_low    (c_low[i+1]),
            .out_quo    (c_quo[i+1]),
            .out_div    (c_div[i+1]),
            .out_neg    (c_neg[i+1]),
            .out_scaled (c_scaled[i+1])
        );
    end

    assign c_ready[QUO_BITS] = !out_valid_reg || m_tready;

    always_comb
    begin
        for (int k = 0; k < NUM_WHEELS; k++)
        begin
            // restore the sign on the zero-extended magnitude
            mag16[k] = WHEEL_BITS'(c_quo[QUO_BITS][k]);
            out_data_next[k*WHEEL_BITS +: WHEEL_BITS] =
                c_neg[QUO_BITS][k] ? (WHEEL_BITS'(0) - mag16[k]) : mag16[k];
        end
        out_valid_next = c_ready[QUO_BITS] ? c_valid[QUO_BITS] : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (c_ready[QUO_BITS] && c_valid[QUO_BITS])
        begin
            out_data_reg   <= out_data_next;
            out_scaled_reg <= c_scaled[QUO_BITS];
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_scaled_reg;

    // divisor is the largest magnitude or one, never zero
    a_div_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        c_valid[0] |-> (c_div[0] != '0))
        else $error("zero divisor entered the cell row");

    // partial remainder starts below the divisor, else the quotient overflows
    a_rem_below_div : assert property (@(posedge clk) disable iff (!rst_n)
        c_valid[0] |-> ((c_rem[0][0] < c_div[0]) && (c_rem[0][1] < c_div[0]) &&
                        (c_rem[0][2] < c_div[0]) && (c_rem[0][3] < c_div[0])))
        else $error("initial remainder not below divisor");

    // unscaled requests travel with a unit divisor to the last cell
    a_unit_div : assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid[QUO_BITS] && !c_scaled[QUO_BITS]) |-> (c_div[QUO_BITS] == MAG_W'(1)))
        else $error("unscaled request carries a non-unit divisor");

endmodule

@@ sv/mwm_front.sv @@
// Front end: wheel mixing, magnitude, largest search and scale product.
`timescale 1ns / 1ps

module mwm_front
    import mwm_pkg::*;
#(
    parameter int VEL_BITS = VEL_BITS_DEFAULT
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  logic signed [VEL_BITS-1:0]                     vel_forward,
    input  logic signed [VEL_BITS-1:0]                     vel_sideways,
    input  logic signed [VEL_BITS-1:0]                     vel_rotate,
    input  logic        [MAX_BITS-1:0]                     max_speed,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output logic        [NUM_WHEELS-1:0][VEL_BITS:0]       out_rem,
    output logic        [NUM_WHEELS-1:0][QUO_BITS-1:0]     out_low,
    output logic        [VEL_BITS:0]                       out_div,
    output logic        [NUM_WHEELS-1:0]                   out_neg,
    output logic                                           out_scaled
);

    localparam int MAG_W  = VEL_BITS + 1;
    localparam int SUM_W  = VEL_BITS + 2;
    localparam int PROD_W = MAG_W + MAX_BITS;
    localparam int CMP_W  = (MAG_W > MAX_BITS) ? MAG_W : MAX_BITS;

    // stage 1: mixed magnitudes
    logic                                 v1_reg, v1_next;
    logic [NUM_WHEELS-1:0][MAG_W-1:0]     mag1_reg, mag1_next;
    logic [NUM_WHEELS-1:0]                neg1_reg, neg1_next;
    // stage 2: divisor and multiplier chosen
    logic                                 v2_reg, v2_next;
    logic [NUM_WHEELS-1:0][MAG_W-1:0]     mag2_reg;
    logic [NUM_WHEELS-1:0]                neg2_reg;
    logic [MAG_W-1:0]                     div2_reg, div2_next;
    logic [MAX_BITS-1:0]                  mul2_reg, mul2_next;
    logic                                 scl2_reg, scl2_next;
    // stage 3: products split into remainder head and dividend tail
    logic                                 v3_reg, v3_next;
    logic [NUM_WHEELS-1:0][MAG_W-1:0]     rem3_reg, rem3_next;
    logic [NUM_WHEELS-1:0][QUO_BITS-1:0]  low3_reg, low3_next;
    logic [NUM_WHEELS-1:0]                neg3_reg;
    logic [MAG_W-1:0]                     div3_reg;
    logic                                 scl3_reg;

    logic rdy1, rdy2, rdy3;

    logic signed [SUM_W-1:0]              fe, se, re;
    logic signed [NUM_WHEELS-1:0][SUM_W-1:0] sum;
    logic        [SUM_W-1:0]              abs_v [NUM_WHEELS];
    logic        [MAG_W-1:0]              l01, l23, largest;
    logic                                 scale;
    logic        [PROD_W-1:0]             prod [NUM_WHEELS];

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        fe = {{2{vel_forward[VEL_BITS-1]}}, vel_forward};
        se = {{2{vel_sideways[VEL_BITS-1]}}, vel_sideways};
        re = {{2{vel_rotate[VEL_BITS-1]}}, vel_rotate};
        sum[0] = fe + se + re;
        sum[1] = fe - se + re;
        sum[2] = fe - se - re;
        sum[3] = fe + se - re;
        for (int k = 0; k < NUM_WHEELS; k++)
        begin
            neg1_next[k] = sum[k][SUM_W-1];
            abs_v[k]     = neg1_next[k] ? (SUM_W'(0) - sum[k]) : sum[k];
            mag1_next[k] = abs_v[k][MAG_W-1:0];
        end
        v1_next = rdy1 ? in_valid : v1_reg;
    end

    always_comb
    begin
        l01     = (mag1_reg[0] > mag1_reg[1]) ? mag1_reg[0] : mag1_reg[1];
        l23     = (mag1_reg[2] > mag1_reg[3]) ? mag1_reg[2] : mag1_reg[3];
        largest = (l01 > l23) ? l01 : l23;
        scale   = CMP_W'(largest) > CMP_W'(max_speed);
        // unscaled wheels pass through as m * 1 / 1
        div2_next = scale ? largest : MAG_W'(1);
        mul2_next = scale ? max_speed : MAX_BITS'(1);
        scl2_next = scale;
        v2_next   = rdy2 ? v1_reg : v2_reg;
    end

    always_comb
    begin
        for (int k = 0; k < NUM_WHEELS; k++)
        begin
            prod[k]      = PROD_W'(mag2_reg[k]) * PROD_W'(mul2_reg);
            rem3_next[k] = prod[k][PROD_W-1:QUO_BITS];
            low3_next[k] = prod[k][QUO_BITS-1:0];
        end
        v3_next = rdy3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            mag1_reg <= mag1_next;
            neg1_reg <= neg1_next;
        end
        if (rdy2 && v1_reg)
        begin
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            div2_reg <= div2_next;
            mul2_reg <= mul2_next;
            scl2_reg <= scl2_next;
        end
        if (rdy3 && v2_reg)
        begin
            rem3_reg <= rem3_next;
            low3_reg <= low3_next;
            neg3_reg <= neg2_reg;
            div3_reg <= div2_reg;
            scl3_reg <= scl2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign out_rem    = rem3_reg;
    assign out_low    = low3_reg;
    assign out_div    = div3_reg;
    assign out_neg    = neg3_reg;
    assign out_scaled = scl3_reg;

endmodule

@@ sv/mwm_div_cell.sv @@
// One restoring-division cell: one quotient bit for all four wheels.
`timescale 1ns / 1ps

module mwm_div_cell
    import mwm_pkg::*;
#(
    parameter int VEL_BITS = VEL_BITS_DEFAULT
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [NUM_WHEELS-1:0][VEL_BITS:0]          in_rem,
    input  logic [NUM_WHEELS-1:0][QUO_BITS-1:0]        in_low,
    input  logic [NUM_WHEELS-1:0][QUO_BITS-1:0]        in_quo,
    input  logic [VEL_BITS:0]                          in_div,
    input  logic [NUM_WHEELS-1:0]                      in_neg,
    input  logic                                       in_scaled,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [NUM_WHEELS-1:0][VEL_BITS:0]          out_rem,
    output logic [NUM_WHEELS-1:0][QUO_BITS-1:0]        out_low,
    output logic [NUM_WHEELS-1:0][QUO_BITS-1:0]        out_quo,
    output logic [VEL_BITS:0]                          out_div,
    output logic [NUM_WHEELS-1:0]                      out_neg,
    output logic                                       out_scaled
);

    localparam int MAG_W = VEL_BITS + 1;

    logic                                 valid_reg, valid_next;
    logic [NUM_WHEELS-1:0][MAG_W-1:0]     rem_reg, rem_next;
    logic [NUM_WHEELS-1:0][QUO_BITS-1:0]  low_reg, low_next;
    logic [NUM_WHEELS-1:0][QUO_BITS-1:0]  quo_reg, quo_next;
    logic [MAG_W-1:0]                     div_reg;
    logic [NUM_WHEELS-1:0]                neg_reg;
    logic                                 scaled_reg;

    logic [MAG_W:0] trial [NUM_WHEELS];
    logic [MAG_W:0] diff  [NUM_WHEELS];
    logic           ge    [NUM_WHEELS];

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        for (int k = 0; k < NUM_WHEELS; k++)
        begin
            // bring down the next dividend bit, subtract if it fits
            trial[k]    = {in_rem[k], in_low[k][QUO_BITS-1]};
            diff[k]     = trial[k] - {1'b0, in_div};
            ge[k]       = trial[k] >= {1'b0, in_div};
            rem_next[k] = ge[k] ? diff[k][MAG_W-1:0] : trial[k][MAG_W-1:0];
            low_next[k] = {in_low[k][QUO_BITS-2:0], 1'b0};
            quo_next[k] = {in_quo[k][QUO_BITS-2:0], ge[k]};
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg    <= rem_next;
            low_reg    <= low_next;
            quo_reg    <= quo_next;
            div_reg    <= in_div;
            neg_reg    <= in_neg;
            scaled_reg <= in_scaled;
        end
    end

    assign out_valid  = valid_reg;
    assign out_rem    = rem_reg;
    assign out_low    = low_reg;
    assign out_quo    = quo_reg;
    assign out_div    = div_reg;
    assign out_neg    = neg_reg;
    assign out_scaled = scaled_reg;

endmodule
